/* rtl/luhn_pkg.sv */
// ----------------------------------------------------------------------------
// luhn_pkg
// shared widths, codes and types of the luhn card number check
// ----------------------------------------------------------------------------
package luhn_pkg;

  // binary input and its decimal form (20 digits cover any 64-bit value)
  localparam int BIN_W       = 64;
  localparam int DIG_W       = 4;
  localparam int BCD_DIGITS  = 20;
  localparam int BCD_W       = BCD_DIGITS * DIG_W;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  localparam int CNT_W       = 5;
  localparam int CLS_W       = 3;

  // issuer class codes
  localparam logic [CLS_W-1:0] CLS_INVALID = 3'd0;
  localparam logic [CLS_W-1:0] CLS_LEAD4   = 3'd1;
  localparam logic [CLS_W-1:0] CLS_LEAD5X  = 3'd2;
  localparam logic [CLS_W-1:0] CLS_LEAD3X  = 3'd3;
  localparam logic [CLS_W-1:0] CLS_OTHER   = 3'd4;

  // lengths and leading digits used by the classification
  localparam logic [CNT_W-1:0] LEN_13 = 5'd13;
  localparam logic [CNT_W-1:0] LEN_15 = 5'd15;
  localparam logic [CNT_W-1:0] LEN_16 = 5'd16;
  localparam logic [CNT_W-1:0] LEN_MAX_LEGAL = 5'd19;

  localparam logic [DIG_W-1:0] DIG_1 = 4'd1;
  localparam logic [DIG_W-1:0] DIG_3 = 4'd3;
  localparam logic [DIG_W-1:0] DIG_4 = 4'd4;
  localparam logic [DIG_W-1:0] DIG_5 = 4'd5;
  localparam logic [DIG_W-1:0] DIG_7 = 4'd7;
  localparam logic [DIG_W-1:0] DIG_9 = 4'd9;

  // one result item
  typedef struct packed {
    logic [CLS_W-1:0] issuer_class;
    logic [CNT_W-1:0] digit_count;
    logic             checksum_ok;
  } luhn_res_t;

  // top level sequencer
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_FIN  = 4'b1000
  } luhn_state_t;

endpackage

/* rtl/luhn_bcd_conv.sv */
// ----------------------------------------------------------------------------
// luhn_bcd_conv
// bit-serial binary to bcd conversion (shift and add 3), one bit per cycle
// ----------------------------------------------------------------------------
module luhn_bcd_conv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [luhn_pkg::BIN_W-1:0]   din,
  output logic                         done,
  output logic [luhn_pkg::BCD_W-1:0]   bcd
);

  localparam int BIT_CNT_W = $clog2(luhn_pkg::BIN_W);

  logic [luhn_pkg::BIN_W-1:0] bin_r, bin_nxt;
  logic [luhn_pkg::BCD_W-1:0] bcd_r, bcd_nxt;
  logic [luhn_pkg::BCD_W-1:0] adj;
  logic [BIT_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < luhn_pkg::BCD_DIGITS; i++) begin
      if (bcd_r[i*luhn_pkg::DIG_W +: luhn_pkg::DIG_W] >= luhn_pkg::DIG_5) begin
        adj[i*luhn_pkg::DIG_W +: luhn_pkg::DIG_W] =
          bcd_r[i*luhn_pkg::DIG_W +: luhn_pkg::DIG_W] + luhn_pkg::DIG_3;
      end else begin
        adj[i*luhn_pkg::DIG_W +: luhn_pkg::DIG_W] =
          bcd_r[i*luhn_pkg::DIG_W +: luhn_pkg::DIG_W];
      end
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = din;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[luhn_pkg::BCD_W-2:0], bin_r[luhn_pkg::BIN_W-1]};
      bin_nxt = {bin_r[luhn_pkg::BIN_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == BIT_CNT_W'(luhn_pkg::BIN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

/* rtl/luhn_digit_scan.sv */
// ----------------------------------------------------------------------------
// luhn_digit_scan
// walks the bcd digits from the least significant one, one digit per cycle:
// luhn sum mod 10, digit count, leading digits and issuer class
// ----------------------------------------------------------------------------
module luhn_digit_scan #(
  parameter int MAX_DIGITS = 19
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [luhn_pkg::BCD_W-1:0]   bcd,
  output logic                         done,
  output luhn_pkg::luhn_res_t          res
);

  localparam logic [3:0] TEN = 4'd10;
  localparam logic [luhn_pkg::CNT_W-1:0] LAST_IDX =
    luhn_pkg::CNT_W'(luhn_pkg::BCD_DIGITS - 1);

  logic [luhn_pkg::BCD_W-1:0]  dig_r, dig_nxt;
  logic [luhn_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [luhn_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [3:0]                  sum_r, sum_nxt;
  logic [luhn_pkg::DIG_W-1:0]  hi_r, hi_nxt;
  logic [luhn_pkg::DIG_W-1:0]  lo_r, lo_nxt;
  logic [luhn_pkg::DIG_W-1:0]  prev_r, prev_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;

  logic [luhn_pkg::DIG_W-1:0]  d;
  logic [4:0]                  dbl;
  logic [3:0]                  contrib;
  logic [4:0]                  acc;

  assign d   = dig_r[luhn_pkg::DIG_W-1:0];
  assign dbl = {d, 1'b0};

  // digits at odd positions are doubled, a two-digit result folds to 1 + units
  always_comb begin
    if (!idx_r[0]) begin
      contrib = d;
    end else if (dbl >= {1'b0, TEN}) begin
      contrib = 4'(dbl - {1'b0, luhn_pkg::DIG_9});
    end else begin
      contrib = dbl[3:0];
    end
    acc = {1'b0, sum_r} + {1'b0, contrib};
  end

  always_comb begin
    dig_nxt  = dig_r;
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    prev_nxt = prev_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dig_nxt  = bcd;
      idx_nxt  = '0;
      cnt_nxt  = '0;
      sum_nxt  = '0;
      hi_nxt   = '0;
      lo_nxt   = '0;
      prev_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dig_nxt  = {{luhn_pkg::DIG_W{1'b0}}, dig_r[luhn_pkg::BCD_W-1:luhn_pkg::DIG_W]};
      idx_nxt  = idx_r + 1'b1;
      sum_nxt  = (acc >= {1'b0, TEN}) ? 4'(acc - {1'b0, TEN}) : acc[3:0];
      prev_nxt = d;
      // the most significant nonzero digit seen so far leads the number
      if (d != '0) begin
        cnt_nxt = idx_r + 1'b1;
        hi_nxt  = d;
        lo_nxt  = prev_r;
      end
      if (idx_r == LAST_IDX) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r  <= dig_nxt;
    cnt_r  <= cnt_nxt;
    sum_r  <= sum_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    prev_r <= prev_nxt;
  end

  // classification from the final scan registers
  always_comb begin
    res = '0;
    if (cnt_r > luhn_pkg::CNT_W'(MAX_DIGITS)) begin
      res.checksum_ok  = 1'b0;
      res.digit_count  = luhn_pkg::CNT_W'(MAX_DIGITS);
      res.issuer_class = luhn_pkg::CLS_INVALID;
    end else begin
      res.checksum_ok = (sum_r == '0);
      res.digit_count = cnt_r;
      if (sum_r != '0) begin
        res.issuer_class = luhn_pkg::CLS_INVALID;
      end else if ((cnt_r inside {luhn_pkg::LEN_13, luhn_pkg::LEN_16}) &&
                   hi_r == luhn_pkg::DIG_4) begin
        res.issuer_class = luhn_pkg::CLS_LEAD4;
      end else if (cnt_r == luhn_pkg::LEN_16 && hi_r == luhn_pkg::DIG_5 &&
                   (lo_r inside {[luhn_pkg::DIG_1:luhn_pkg::DIG_5]})) begin
        res.issuer_class = luhn_pkg::CLS_LEAD5X;
      end else if (cnt_r == luhn_pkg::LEN_15 && hi_r == luhn_pkg::DIG_3 &&
                   (lo_r inside {luhn_pkg::DIG_4, luhn_pkg::DIG_7})) begin
        res.issuer_class = luhn_pkg::CLS_LEAD3X;
      end else begin
        res.issuer_class = luhn_pkg::CLS_OTHER;
      end
    end
  end

  assign done = done_r;

endmodule

/* rtl/luhn_card_number_check.sv */
// ----------------------------------------------------------------------------
// luhn_card_number_check
// luhn mod-10 card number check with digit count and issuer class
// ----------------------------------------------------------------------------
// One item in, one item out. An accepted card number first runs through a
// bit-serial binary to bcd converter (one input bit per cycle), then a digit
// scanner walks the 20 bcd digits from the least significant one (one digit
// per cycle), building the luhn sum mod 10, the digit count and the two
// leading digits. The sequencer then loads the classified result into the
// output register and returns to idle; only then can the next item be
// accepted, so the block takes no new item while one is in flight.
// A result still waiting on out_tready when the next one is ready holds the
// block until it leaves. in_tready is high while the block is idle, also
// while a finished result still waits on out_tready.
// Numbers with more than MAX_DIGITS digits fail with class 0 and a digit
// count of MAX_DIGITS; zero passes with count 0 and class 4.
// ----------------------------------------------------------------------------
module luhn_card_number_check #(
  parameter int MAX_DIGITS = 19
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input item
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [luhn_pkg::IN_TDATA_W-1:0]    in_tdata,   // [63:0] card_number
  // result item
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] checksum_ok, [5:1] digit_count, [8:6] issuer_class, [15:9] zero
  output logic [luhn_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int RES_W = $bits(luhn_pkg::luhn_res_t);

  luhn_pkg::luhn_state_t state_r, state_nxt;

  logic                        in_acc;
  logic                        conv_done;
  logic [luhn_pkg::BCD_W-1:0]  conv_bcd;
  logic                        scan_done;
  luhn_pkg::luhn_res_t         scan_res;

  logic                        out_vld_r, out_vld_nxt;
  luhn_pkg::luhn_res_t         out_res_r, out_res_nxt;
  logic                        out_free;

  assign in_tready = (state_r == luhn_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  // binary to decimal, one bit a cycle
  luhn_bcd_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .din   (in_tdata[luhn_pkg::BIN_W-1:0]),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  // luhn sum, count and class, one digit a cycle
  luhn_digit_scan #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_done),
    .bcd   (conv_bcd),
    .done  (scan_done),
    .res   (scan_res)
  );

  // sequencer: idle, converting, scanning, waiting for the output register
  always_comb begin
    state_nxt   = state_r;
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    case (state_r)
      luhn_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = luhn_pkg::ST_CONV;
        end
      end
      luhn_pkg::ST_CONV: begin
        if (conv_done) begin
          state_nxt = luhn_pkg::ST_SCAN;
        end
      end
      luhn_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = luhn_pkg::ST_FIN;
        end
      end
      luhn_pkg::ST_FIN: begin
        // scan results stay put until the next start, so waiting here is safe
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_res_nxt = scan_res;
          state_nxt   = luhn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = luhn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= luhn_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(luhn_pkg::OUT_TDATA_W - RES_W){1'b0}}, out_res_r};

endmodule

/* rtl/luhn_check_sva.sv */
// ----------------------------------------------------------------------------
// luhn_check_sva
// port-level checks of the luhn card number check, bound to the top level
// ----------------------------------------------------------------------------
module luhn_check_sva (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [luhn_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic [luhn_pkg::CLS_W-1:0] cls;
  logic [luhn_pkg::CNT_W-1:0] cnt;
  logic                       ok;

  assign ok  = out_tdata[0];
  assign cnt = out_tdata[5:1];
  assign cls = out_tdata[8:6];

  // one item at a time: an accepted item makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready stayed high after an accepted item");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // a class is given exactly when the checksum passes
  a_class_vs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ok == (cls != luhn_pkg::CLS_INVALID)))
    else $error("issuer class disagrees with checksum result");

  // leading-4 class only for 13 or 16 digits, count never above 19
  a_class_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (cnt <= luhn_pkg::LEN_MAX_LEGAL) &&
                   ((cls != luhn_pkg::CLS_LEAD4) ||
                    cnt == luhn_pkg::LEN_13 || cnt == luhn_pkg::LEN_16))
    else $error("digit count inconsistent with issuer class");

endmodule

bind luhn_card_number_check luhn_check_sva u_luhn_check_sva (.*);
